// ===== rtl/core/rtp_pkg.sv =====
package rtp_pkg;

    localparam int TAG_SLOTS_DEF = 8;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_CHECK = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] ST_UPDATED = 3'd0;
    localparam logic [2:0] ST_NEW     = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BAD     = 3'd3;
    localparam logic [2:0] ST_CHECK   = 3'd4;
    localparam logic [2:0] ST_READ    = 3'd5;

    localparam logic [7:0] HDR0 = 8'h1B;
    localparam logic [7:0] HDR1 = 8'h39;
    localparam logic [7:0] HDR2 = 8'h01;

    localparam logic [3:0] FRAME_MIN = 4'd14;
    localparam logic [3:0] POS_RSSI  = 4'd7;
    localparam logic [3:0] POS_BATT  = 4'd9;
    localparam logic [3:0] POS_UID0  = 4'd10;
    localparam logic [3:0] POS_UID3  = 4'd13;

    localparam logic [31:0] TIMEOUT_RST = 32'd1000;

    localparam int       PADDR_W        = 3;
    localparam logic     REG_IDX_TIMEOUT = 1'b0;

    typedef struct packed {
        logic        done;
        logic        good;
        logic [7:0]  rssi;
        logic [7:0]  battery;
        logic [31:0] uid;
    } frame_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot_index;
        logic [7:0]  valid_map;
        logic [7:0]  expired_map;
        logic [31:0] tag_id;
        logic [7:0]  signal_level;
        logic [7:0]  battery_level;
    } result_t;

endpackage

// ===== rtl/core/rtp_frame_asm.sv =====
module rtp_frame_asm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [1:0]      op,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output rtp_pkg::frame_t frame
);
    import rtp_pkg::*;

    logic [3:0]  count_reg, count_next;
    logic        good_reg, good_next;
    logic [7:0]  rssi_reg, rssi_next;
    logic [7:0]  batt_reg, batt_next;
    logic [31:0] uid_reg, uid_next;
    logic        hdr_bad;
    logic        is_byte;

    assign is_byte = (op == OP_BYTE);

    always_comb
    begin
        hdr_bad = ((count_reg == 4'd0) && (data_byte != HDR0)) ||
                  ((count_reg == 4'd1) && (data_byte != HDR1)) ||
                  ((count_reg == 4'd2) && (data_byte != HDR2));
        good_next  = good_reg && !hdr_bad;
        rssi_next  = (count_reg == POS_RSSI) ? data_byte : rssi_reg;
        batt_next  = (count_reg == POS_BATT) ? data_byte : batt_reg;
        uid_next   = ((count_reg >= POS_UID0) && (count_reg <= POS_UID3)) ?
                     {uid_reg[23:0], data_byte} : uid_reg;
        count_next = (count_reg < FRAME_MIN) ? count_reg + 4'd1 : count_reg;
    end

    always_comb
    begin
        frame.done    = is_byte && last_byte;
        frame.good    = good_next && (count_next == FRAME_MIN);
        frame.rssi    = rssi_next;
        frame.battery = batt_next;
        frame.uid     = uid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            good_reg  <= 1'b1;
            rssi_reg  <= '0;
            batt_reg  <= '0;
            uid_reg   <= '0;
        end
        else if (advance && is_byte)
        begin
            if (last_byte)
            begin
                count_reg <= '0;
                good_reg  <= 1'b1;
                rssi_reg  <= '0;
                batt_reg  <= '0;
                uid_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                good_reg  <= good_next;
                rssi_reg  <= rssi_next;
                batt_reg  <= batt_next;
                uid_reg   <= uid_next;
            end
        end
    end

endmodule

// ===== rtl/core/rtp_slot_table.sv =====
module rtp_slot_table #(
    parameter int TAG_SLOTS = rtp_pkg::TAG_SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [1:0]       op,
    input  logic [31:0]      now_tick,
    input  logic [2:0]       slot_select,
    input  logic [31:0]      offline_timeout,
    input  rtp_pkg::frame_t  frame,
    output rtp_pkg::result_t result,
    output logic             has_result
);
    import rtp_pkg::*;

    localparam int SLOT_W = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;

    logic [TAG_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0]          uid_mem  [TAG_SLOTS];
    logic [7:0]           rssi_mem [TAG_SLOTS];
    logic [7:0]           batt_mem [TAG_SLOTS];
    logic [31:0]          seen_mem [TAG_SLOTS];

    logic [TAG_SLOTS-1:0] match_vec, free_vec, expire_vec;
    logic [SLOT_W-1:0]    match_idx, free_idx, wr_idx, sel_idx;
    logic [7:0]           wr_idx_ext;
    logic [5:0]           sel_ext;
    logic                 read_ok;
    logic                 wr_en;
    logic [7:0]           valid_map8, expire_map8;

    always_comb
    begin
        for (int i = 0; i < TAG_SLOTS; i++)
        begin
            match_vec[i]  = valid_reg[i] && (uid_mem[i] == frame.uid);
            free_vec[i]   = !valid_reg[i];
            expire_vec[i] = valid_reg[i] && ((now_tick - seen_mem[i]) > offline_timeout);
        end
    end

    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = TAG_SLOTS - 1; i >= 0; i--)
        begin
            if (match_vec[i])
                match_idx = SLOT_W'(i);
            if (free_vec[i])
                free_idx = SLOT_W'(i);
        end
    end

    assign sel_ext = {3'b000, slot_select};
    assign sel_idx = sel_ext[SLOT_W-1:0];
    assign read_ok = (sel_ext < 6'(TAG_SLOTS)) && valid_reg[sel_idx];

    for (genvar g = 0; g < 8; g++)
    begin : g_map
        if (g < TAG_SLOTS)
        begin : g_live
            assign valid_map8[g]  = valid_next[g];
            assign expire_map8[g] = expire_vec[g];
        end
        else
        begin : g_none
            assign valid_map8[g]  = 1'b0;
            assign expire_map8[g] = 1'b0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        wr_en      = 1'b0;
        wr_idx     = match_idx;
        has_result = 1'b0;
        result     = '0;
        case (op)
            OP_BYTE:
            begin
                if (frame.done)
                begin
                    has_result = 1'b1;
                    if (!frame.good)
                        result.status = ST_BAD;
                    else
                    begin
                        result.tag_id        = frame.uid;
                        result.signal_level  = frame.rssi;
                        result.battery_level = frame.battery;
                        if (|match_vec)
                        begin
                            wr_en         = 1'b1;
                            result.status = ST_UPDATED;
                        end
                        else if (|free_vec)
                        begin
                            wr_en               = 1'b1;
                            wr_idx              = free_idx;
                            valid_next[free_idx] = 1'b1;
                            result.status       = ST_NEW;
                        end
                        else
                            result.status = ST_FULL;
                    end
                end
            end
            OP_CHECK:
            begin
                has_result         = 1'b1;
                valid_next         = valid_reg & ~expire_vec;
                result.status      = ST_CHECK;
                result.expired_map = expire_map8;
            end
            OP_READ:
            begin
                has_result        = 1'b1;
                result.status     = ST_READ;
                result.slot_index = slot_select;
                if (read_ok)
                begin
                    result.tag_id        = uid_mem[sel_idx];
                    result.signal_level  = rssi_mem[sel_idx];
                    result.battery_level = batt_mem[sel_idx];
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
        wr_idx_ext = 8'(wr_idx);
        if (wr_en)
            result.slot_index = wr_idx_ext[2:0];
        result.valid_map = valid_map8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && wr_en)
        begin
            uid_mem[wr_idx]  <= frame.uid;
            rssi_mem[wr_idx] <= frame.rssi;
            batt_mem[wr_idx] <= frame.battery;
            seen_mem[wr_idx] <= now_tick;
        end
    end

endmodule

// ===== rtl/core/rfid_tag_presence_table.sv =====
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    op, data_byte, last_byte, now_tick, slot_select
// out      out  out_valid/out_ready  status, slot_index, valid_map, expired_map,
//                                    tag_id, signal_level, battery_level
// cfg      in   APB psel/penable     paddr, pwrite, pwdata, prdata, pready
//
// One item per cycle sustained while out_ready stays high; a result is loaded into
// the output register as its item leaves the input register (input register, then
// slot compare/update logic into the output register).
// rst_n clears the slot valid map, the frame assembler and the valid flags of both registers.
// A stalled output register holds the next item in the input register;
// in_ready follows out_ready combinationally.
module rfid_tag_presence_table #(
    parameter int TAG_SLOTS = rtp_pkg::TAG_SLOTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    input  logic [31:0]                now_tick,
    input  logic [2:0]                 slot_select,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 status,
    output logic [2:0]                 slot_index,
    output logic [7:0]                 valid_map,
    output logic [7:0]                 expired_map,
    output logic [31:0]                tag_id,
    output logic [7:0]                 signal_level,
    output logic [7:0]                 battery_level,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rtp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rtp_pkg::*;

    logic            in_valid_reg;
    logic [1:0]      op_reg;
    logic [7:0]      byte_reg;
    logic            last_reg;
    logic [31:0]     now_reg;
    logic [2:0]      sel_reg;
    logic            advance;
    logic            out_valid_reg;
    result_t         out_reg;
    result_t         result;
    logic            has_result;
    frame_t          frame;
    logic [31:0]     timeout_reg;
    logic            reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1];
    assign prdata  = (reg_idx == REG_IDX_TIMEOUT) ? timeout_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RST;
        else if (psel && penable && pwrite && (reg_idx == REG_IDX_TIMEOUT))
            timeout_reg <= pwdata;
    end

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= op;
            byte_reg <= data_byte;
            last_reg <= last_byte;
            now_reg  <= now_tick;
            sel_reg  <= slot_select;
        end
    end

    rtp_frame_asm u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .op        (op_reg),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .frame     (frame)
    );

    rtp_slot_table #(
        .TAG_SLOTS (TAG_SLOTS)
    ) u_table (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .op              (op_reg),
        .now_tick        (now_reg),
        .slot_select     (sel_reg),
        .offline_timeout (timeout_reg),
        .frame           (frame),
        .result          (result),
        .has_result      (has_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= has_result;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
            out_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign slot_index    = out_reg.slot_index;
    assign valid_map     = out_reg.valid_map;
    assign expired_map   = out_reg.expired_map;
    assign tag_id        = out_reg.tag_id;
    assign signal_level  = out_reg.signal_level;
    assign battery_level = out_reg.battery_level;

endmodule

// ===== rtl/core/rtp_checker.sv =====
module rtp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [2:0]  slot_index,
    input logic [7:0]  expired_map,
    input logic [31:0] tag_id,
    input logic [7:0]  signal_level,
    input logic [7:0]  battery_level
);
    import rtp_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(tag_id))
        else $error("result changed while stalled");

    // a new result needs an item accepted earlier
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without accepted item");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_BAD) |->
            (tag_id == 32'd0) && (signal_level == 8'd0) && (battery_level == 8'd0) &&
            (slot_index == 3'd0) && (expired_map == 8'd0))
        else $error("bad frame result not cleared");

    a_check_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_CHECK) |-> (slot_index == 3'd0) && (tag_id == 32'd0))
        else $error("check result carries slot data");

    a_expired_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_CHECK) |-> (expired_map == 8'd0))
        else $error("expired map outside check");

endmodule

bind rfid_tag_presence_table rtp_checker u_rtp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slot_index    (slot_index),
    .expired_map   (expired_map),
    .tag_id        (tag_id),
    .signal_level  (signal_level),
    .battery_level (battery_level)
);

// ===== sim/tb_rfid_tag_presence_table.sv =====
`timescale 1ns / 100ps

module tb_rfid_tag_presence_table;
    import rtp_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = {REG_IDX_TIMEOUT, 2'b00};
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS = 200;
    localparam int UID_POOL = 12;

    class tag_table_tracker;
        logic [31:0] timeout_ticks;
        logic [7:0]  valid_bits;
        logic [31:0] uid_tbl[8];
        logic [7:0]  rssi_tbl[8];
        logic [7:0]  batt_tbl[8];
        logic [31:0] seen_tbl[8];
        logic [3:0]  byte_cnt;
        logic        hdr_ok;
        logic [7:0]  cap_rssi;
        logic [7:0]  cap_batt;
        logic [31:0] cap_uid;
        result_t     pending_reports[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned status_seen[8];

        function new();
            timeout_ticks = TIMEOUT_RST;
            valid_bits = '0;
            errors = 0;
            checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            foreach (uid_tbl[i])
            begin
                uid_tbl[i] = '0;
                rssi_tbl[i] = '0;
                batt_tbl[i] = '0;
                seen_tbl[i] = '0;
            end
            clear_frame();
        endfunction

        function void clear_frame();
            byte_cnt = '0;
            hdr_ok = 1'b1;
            cap_rssi = '0;
            cap_batt = '0;
            cap_uid = '0;
        endfunction

        function void set_timeout(logic [31:0] v);
            timeout_ticks = v;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function void take_item(logic [1:0] op_i, logic [7:0] b, logic last,
                                logic [31:0] now, logic [2:0] sel);
            result_t r;
            logic [3:0] pos;
            logic [31:0] age;
            int hit;
            int i;
            r = '0;
            case (op_i)
                OP_BYTE:
                begin
                    pos = byte_cnt;
                    if ((pos == 4'd0 && b != HDR0) || (pos == 4'd1 && b != HDR1) ||
                        (pos == 4'd2 && b != HDR2))
                        hdr_ok = 1'b0;
                    if (pos == POS_RSSI) cap_rssi = b;
                    if (pos == POS_BATT) cap_batt = b;
                    if (pos >= POS_UID0 && pos <= POS_UID3) cap_uid = {cap_uid[23:0], b};
                    if (byte_cnt < FRAME_MIN) byte_cnt = byte_cnt + 4'd1;
                    if (last)
                    begin
                        if (byte_cnt < FRAME_MIN || !hdr_ok)
                        begin
                            r.status = ST_BAD;
                        end
                        else
                        begin
                            hit = -1;
                            for (i = 0; i < 8; i++)
                                if (hit < 0 && valid_bits[i] && uid_tbl[i] == cap_uid) hit = i;
                            r.status = ST_UPDATED;
                            if (hit < 0)
                            begin
                                for (i = 0; i < 8; i++)
                                    if (hit < 0 && !valid_bits[i]) hit = i;
                                if (hit >= 0)
                                begin
                                    valid_bits[hit] = 1'b1;
                                    uid_tbl[hit] = cap_uid;
                                    r.status = ST_NEW;
                                end
                                else
                                begin
                                    r.status = ST_FULL;
                                end
                            end
                            if (hit >= 0)
                            begin
                                rssi_tbl[hit] = cap_rssi;
                                batt_tbl[hit] = cap_batt;
                                seen_tbl[hit] = now;
                                r.slot_index = hit[2:0];
                            end
                            r.tag_id = cap_uid;
                            r.signal_level = cap_rssi;
                            r.battery_level = cap_batt;
                        end
                        r.valid_map = valid_bits;
                        clear_frame();
                        pending_reports.push_back(r);
                    end
                end
                OP_CHECK:
                begin
                    for (i = 0; i < 8; i++)
                    begin
                        age = now - seen_tbl[i];
                        if (valid_bits[i] && age > timeout_ticks)
                        begin
                            valid_bits[i] = 1'b0;
                            r.expired_map[i] = 1'b1;
                        end
                    end
                    r.status = ST_CHECK;
                    r.valid_map = valid_bits;
                    pending_reports.push_back(r);
                end
                OP_READ:
                begin
                    r.status = ST_READ;
                    r.slot_index = sel;
                    r.valid_map = valid_bits;
                    if (valid_bits[sel])
                    begin
                        r.tag_id = uid_tbl[sel];
                        r.signal_level = rssi_tbl[sel];
                        r.battery_level = batt_tbl[sel];
                    end
                    pending_reports.push_back(r);
                end
                default: ;
            endcase
        endfunction

        task report(string what, logic [31:0] got_v, logic [31:0] want_v);
            if (errors < 20)
                $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got_v, want_v, $realtime);
            errors++;
        endtask

        task check_report(result_t got);
            result_t want;
            if (pending_reports.size() == 0)
            begin
                report("unexpected result, status", 32'(got.status), '0);
                return;
            end
            want = pending_reports.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.status != want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.slot_index != want.slot_index)
                report("slot_index", 32'(got.slot_index), 32'(want.slot_index));
            if (got.valid_map != want.valid_map)
                report("valid_map", 32'(got.valid_map), 32'(want.valid_map));
            if (got.expired_map != want.expired_map)
                report("expired_map", 32'(got.expired_map), 32'(want.expired_map));
            if (got.tag_id != want.tag_id) report("tag_id", got.tag_id, want.tag_id);
            if (got.signal_level != want.signal_level)
                report("signal_level", 32'(got.signal_level), 32'(want.signal_level));
            if (got.battery_level != want.battery_level)
                report("battery_level", 32'(got.battery_level), 32'(want.battery_level));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          op;
    logic [7:0]          data_byte;
    logic                last_byte;
    logic [31:0]         now_tick;
    logic [2:0]          slot_select;
    logic                out_valid;
    logic                out_ready;
    logic [2:0]          status;
    logic [2:0]          slot_index;
    logic [7:0]          valid_map;
    logic [7:0]          expired_map;
    logic [31:0]         tag_id;
    logic [7:0]          signal_level;
    logic [7:0]          battery_level;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    tag_table_tracker book;
    int unsigned items_sent = 0;
    int unsigned settings_done = 0;
    int unsigned cycles = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    logic [31:0] tick_now = '0;
    logic [31:0] uid_pool[UID_POOL];

    rfid_tag_presence_table u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .data_byte(data_byte), .last_byte(last_byte),
        .now_tick(now_tick), .slot_select(slot_select),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .slot_index(slot_index), .valid_map(valid_map),
        .expired_map(expired_map), .tag_id(tag_id), .signal_level(signal_level),
        .battery_level(battery_level),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            book.take_item(op, data_byte, last_byte, now_tick, slot_select);
        if (rst_n && out_valid && out_ready)
            book.check_report({status, slot_index, valid_map, expired_map,
                               tag_id, signal_level, battery_level});
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, book.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] o, input logic [7:0] b, input logic l,
                             input logic [31:0] t, input logic [2:0] s);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        data_byte <= b;
        last_byte <= l;
        now_tick <= t;
        slot_select <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (o != OP_NONE) items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (book.pending() != 0);
    endtask

    task automatic write_timeout(input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TIMEOUT_ADDR;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        book.set_timeout(v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        settings_done++;
    endtask

    task automatic send_side_op();
        int k;
        k = $urandom_range(19);
        if (k < 8)
            send_item(OP_CHECK, 8'($urandom), 1'($urandom), tick_now + $urandom_range(400),
                      3'($urandom));
        else if (k < 18)
            send_item(OP_READ, 8'($urandom), 1'($urandom), $urandom, 3'($urandom));
        else
            send_item(OP_NONE, 8'($urandom), 1'($urandom), $urandom, 3'($urandom));
    endtask

    task automatic send_frame(input logic [31:0] uid, input logic [7:0] rssi,
                              input logic [7:0] batt, input int len, input bit spoil);
        logic [7:0] b;
        int p;
        int bad_pos;
        bad_pos = spoil ? $urandom_range(2) : -1;
        for (p = 0; p < len; p++)
        begin
            case (p)
                0: b = HDR0;
                1: b = HDR1;
                2: b = HDR2;
                7: b = rssi;
                9: b = batt;
                10: b = uid[31:24];
                11: b = uid[23:16];
                12: b = uid[15:8];
                13: b = uid[7:0];
                default: b = 8'($urandom);
            endcase
            if (p == bad_pos) b = b ^ (8'd1 << $urandom_range(7));
            if ($urandom_range(99) < 4) send_side_op();
            send_item(OP_BYTE, b, p == len - 1, (p == len - 1) ? tick_now : $urandom,
                      3'($urandom));
        end
    endtask

    task automatic run_phase(input logic [31:0] tmo, input int mode);
        int goal;
        int k;
        int m;
        int n;
        bit drained;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_timeout(tmo);
        in_idle_pct = (mode == 1) ? 53 : (mode == 3) ? 18 : 0;
        out_stall_pct = (mode == 2) ? 53 : (mode == 3) ? 18 : 0;
        foreach (uid_pool[i]) uid_pool[i] = $urandom;
        goal = items_sent + PHASE_ITEMS;
        drained = 0;
        while (items_sent < goal)
        begin
            k = $urandom_range(99);
            if (k < 68)
            begin
                if ($urandom_range(99) < 3) tick_now = $urandom;
                else tick_now = tick_now + $urandom_range(60);
                m = $urandom_range(99);
                send_frame(uid_pool[$urandom_range(UID_POOL - 1)], 8'($urandom),
                           8'($urandom),
                           (m < 82 || m >= 95) ? 14 : (m < 90) ? $urandom_range(15, 17)
                                                            : $urandom_range(1, 13),
                           m >= 95);
            end
            else if (k < 94)
            begin
                send_side_op();
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_item(OP_BYTE, 8'($urandom), 1'($urandom_range(1)), tick_now,
                              3'($urandom));
            end
            if (!drained && items_sent + 100 >= goal)
            begin
                drain();
                drained = 1;
            end
        end
    endtask

    initial
    begin
        book = new();
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        op <= OP_BYTE;
        data_byte <= '0;
        last_byte <= 1'b0;
        now_tick <= '0;
        slot_select <= '0;
        out_ready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_timeout(TIMEOUT_RST);

        // extreme uid/rssi, new tag at tick 0, reads, expiry at the maximum tick, op 3, short frame
        send_frame(32'hFFFF_FFFF, 8'hFF, 8'h00, 14, 0);
        send_item(OP_READ, 8'h00, 1'b0, 32'h0, 3'd0);
        send_item(OP_READ, 8'hFF, 1'b1, 32'hFFFF_FFFF, 3'd7);
        send_item(OP_CHECK, 8'h00, 1'b0, 32'hFFFF_FFFF, 3'd0);
        send_item(OP_READ, 8'h00, 1'b0, 32'h0, 3'd0);
        send_item(OP_NONE, 8'hFF, 1'b1, 32'hFFFF_FFFF, 3'd7);
        send_item(OP_BYTE, 8'h00, 1'b1, 32'h0, 3'd0);

        run_phase(32'd1000, 0);
        run_phase(32'd0, 1);
        run_phase(32'hFFFF_FFFF, 2);
        tick_now = 32'hFFFF_FF00;
        run_phase(32'd300, 3);
        run_phase($urandom_range(500), 1);
        run_phase(32'd100, 2);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d items, %0d results, %0d timeout settings", items_sent,
                 book.checked, settings_done);
        $display("results: %0d updated %0d new %0d full %0d bad %0d check %0d read",
                 book.status_seen[ST_UPDATED], book.status_seen[ST_NEW],
                 book.status_seen[ST_FULL], book.status_seen[ST_BAD],
                 book.status_seen[ST_CHECK], book.status_seen[ST_READ]);
        if (book.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== rfid_tag_presence_table.f =====
rtl/core/rtp_pkg.sv
rtl/core/rtp_frame_asm.sv
rtl/core/rtp_slot_table.sv
rtl/core/rfid_tag_presence_table.sv
rtl/core/rtp_checker.sv
sim/tb_rfid_tag_presence_table.sv
